// ----- hw/rtl/msbr_pkg.sv -----
// msbr_pkg: shared types and constants for the msb-first bitstream reader
// no dependencies; imported by msbr_front, msbr_back and the top level

package msbr_pkg;

  // fixed field widths of the word interface
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int VALUE_W  = 24;
  localparam int STATUS_W = 2;

  // look-ahead window: largest alignment skip plus largest count
  localparam int WIN_BITS = 32;
  localparam int SHAMT_W  = 6;

  localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'h7F;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_GET   = 2'd2,
    OP_ALIGN = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one classified word waiting for the back end
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // queue state seen by the back end
  typedef struct packed {
    logic head_valid;
  } q_stat_t;

endpackage

// ----- hw/rtl/msbr_front.sv -----
// msbr_front: input acceptance, mode decode and count saturation,
// feeding a short queue toward the back end; depends on msbr_pkg

module msbr_front #(
  parameter int MAX_PEEK = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [msbr_pkg::MODE_W-1:0]     in_mode,
  input  logic [msbr_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [msbr_pkg::COUNT_W-1:0]    in_bit_count,
  input  logic                            pop,
  output msbr_pkg::entry_t                head,
  output msbr_pkg::q_stat_t               q_stat
);
  import msbr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  entry_t             incoming;
  logic               push;

  // classify the incoming word: decode mode, clamp the count
  always_comb begin
    incoming.op    = op_t'(in_mode);
    incoming.data  = in_data_byte;
    incoming.count = (in_bit_count > COUNT_W'(MAX_PEEK)) ? COUNT_W'(MAX_PEEK) : in_bit_count;
  end

  assign in_stall          = (level_r == LVL_W'(QUEUE_DEPTH));
  assign push              = in_valid && !in_stall;
  assign head              = slot_r[rd_ptr_r];
  assign q_stat.head_valid = (level_r != '0);

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

// ----- hw/rtl/msbr_back.sv -----
// msbr_back: bit buffer, fill count and execution of push, peek, get and
// aligned peek, with the result output register; depends on msbr_pkg

module msbr_back #(
  parameter int BUFFER_BITS = 64,
  parameter int HELD_W      = $clog2(BUFFER_BITS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  msbr_pkg::entry_t                head,
  input  msbr_pkg::q_stat_t               q_stat,
  output logic                            pop,
  output logic [HELD_W-1:0]               held,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [msbr_pkg::VALUE_W-1:0]    out_bits_value,
  output logic [msbr_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_byte_aligned
);
  import msbr_pkg::*;

  // buffer is msb-first: bit BUFFER_BITS-1 is the next bit to read
  logic [BUFFER_BITS-1:0] buf_r, buf_nxt;
  logic [HELD_W-1:0]      held_r, held_nxt;
  logic                   out_valid_r;
  logic [VALUE_W-1:0]     value_r, value_nxt;
  status_t                status_r, status_nxt;
  logic                   aligned_r;

  logic [WIN_BITS-1:0]    top;
  logic [WIN_BITS-1:0]    window;
  logic [WIN_BITS-1:0]    mask;
  logic [WIN_BITS-1:0]    picked;
  logic [3:0]             skip;
  logic [SHAMT_W-1:0]     need;
  logic                   stuffed;
  logic                   short_buf;
  logic                   full_buf;
  logic [HELD_W-1:0]      push_shamt;

  assign pop  = q_stat.head_valid && (!out_valid_r || !out_stall);
  assign held = held_r;

  // look-ahead window and alignment skip
  always_comb begin
    top     = buf_r[BUFFER_BITS-1 -: WIN_BITS];
    stuffed = (held_r >= HELD_W'(8)) && (top[WIN_BITS-1 -: BYTE_W] == STUFF_BYTE);
    skip    = 4'd0;
    if (head.op == OP_ALIGN) begin
      if (held_r[2:0] != 3'd0) begin
        skip = {1'b0, held_r[2:0]};
      end else if (stuffed) begin
        skip = 4'd8;
      end
    end
    need      = SHAMT_W'(skip) + SHAMT_W'(head.count);
    short_buf = ((HELD_W + 1)'(need) > (HELD_W + 1)'(held_r));
    window    = top >> (SHAMT_W'(WIN_BITS) - need);
    mask      = {WIN_BITS{1'b1}} >> (SHAMT_W'(WIN_BITS) - SHAMT_W'(head.count));
    picked    = window & mask;
    full_buf  = ((HELD_W + 1)'(held_r) + (HELD_W + 1)'(8)) > (HELD_W + 1)'(BUFFER_BITS);
    push_shamt = HELD_W'(BUFFER_BITS - 8) - held_r;
  end

  // execute the head word
  always_comb begin
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    value_nxt  = '0;
    status_nxt = ST_OK;
    unique case (head.op) inside
      OP_PUSH: begin
        if (full_buf) begin
          status_nxt = ST_FULL;
        end else begin
          buf_nxt  = buf_r | (BUFFER_BITS'(head.data) << push_shamt);
          held_nxt = held_r + HELD_W'(8);
        end
      end
      OP_PEEK, OP_GET, OP_ALIGN: begin
        if (head.count == '0) begin
          value_nxt = '0;
        end else if (short_buf) begin
          status_nxt = ST_SHORT;
        end else begin
          value_nxt = VALUE_W'(picked);
          if (head.op == OP_GET) begin
            buf_nxt  = buf_r << head.count;
            held_nxt = held_r - HELD_W'(head.count);
          end
        end
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      value_r   <= value_nxt;
      status_r  <= status_nxt;
      aligned_r <= (held_nxt[2:0] == 3'd0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bits_value   = value_r;
  assign out_status       = status_r;
  assign out_byte_aligned = aligned_r;

endmodule

// ----- hw/rtl/msb_first_bitstream_reader.sv -----
// msb_first_bitstream_reader: an accepted word is written into the queue,
// then executed on the bit buffer in msbr_back into the result register; one
// word per cycle is taken while the result output is not stalled.
// a two-entry queue decouples input acceptance from result back-pressure.
// reset (synchronous, rst_n low) clears the bit buffer, fill count, queue
// and output valid.

module msb_first_bitstream_reader #(
  parameter int BUFFER_BITS = 64,
  parameter int MAX_PEEK    = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [msbr_pkg::MODE_W-1:0]     in_mode,
  input  logic [msbr_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [msbr_pkg::COUNT_W-1:0]    in_bit_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [msbr_pkg::VALUE_W-1:0]    out_bits_value,
  output logic [msbr_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_byte_aligned
);
  import msbr_pkg::*;

  localparam int HELD_W = $clog2(BUFFER_BITS + 1);

  entry_t            head;
  q_stat_t           q_stat;
  logic              pop;
  logic [HELD_W-1:0] held;

  // front: accept and classify
  msbr_front #(
    .MAX_PEEK (MAX_PEEK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_bit_count (in_bit_count),
    .pop          (pop),
    .head         (head),
    .q_stat       (q_stat)
  );

  // back: bit buffer and results
  msbr_back #(
    .BUFFER_BITS (BUFFER_BITS),
    .HELD_W      (HELD_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .held             (held),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bits_value   (out_bits_value),
    .out_status       (out_status),
    .out_byte_aligned (out_byte_aligned)
  );

  // fill count never passes the buffer size
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held <= HELD_W'(BUFFER_BITS))
    else $error("bit buffer fill count above buffer size");

  // an accepted word is waiting in the queue on the next cycle
  a_queue_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_stat.head_valid)
    else $error("accepted word missing from queue");

  // the back end never overwrites a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

endmodule
